FILE: rtl/knn_pkg.sv
// ----------------------------------------------------------------------------
// knn_pkg: shared types and constants of the L1 nearest-neighbor classifier
// Word layouts of both channels, the queue tag, the back-end states and the
// fixed sizes of the neighbor list and the vote.
// ----------------------------------------------------------------------------
package knn_pkg;

  // Field widths fixed by the word layouts.
  localparam int PIXEL_BITS = 8;
  localparam int CLS_BITS   = 4;

  // Default width of the distance accumulator and of the stored distances.
  localparam int DIST_BITS_DEF = 20;

  // Size of the neighbor list and the number of classes that may vote.
  localparam int NEIGHBOR_COUNT = 5;
  localparam int CLASS_COUNT    = 10;

  // Ranks run 0 .. NEIGHBOR_COUNT-1 and are compared against k up to NEIGHBOR_COUNT.
  localparam int RANK_BITS = $clog2(NEIGHBOR_COUNT + 1);

  // The three vote sizes: nearest one, three and five.
  localparam int K_COUNT = 3;
  localparam logic [RANK_BITS-1:0] K_VALUES [K_COUNT] = '{
    RANK_BITS'(1), RANK_BITS'(3), RANK_BITS'(5)
  };

  // Depth of the queue between front and back end; a power of two, at least 2.
  localparam int QUEUE_DEPTH = 2;

  // One input word: a query byte and the matching training byte.
  typedef struct packed {
    logic [PIXEL_BITS-1:0] query_pixel;
    logic [PIXEL_BITS-1:0] train_pixel;
    logic [CLS_BITS-1:0]   train_class;
    logic [CLS_BITS-1:0]   query_class;
    logic                  end_of_vector;
    logic                  end_of_set;
  } knn_in_t;

  // One result word: three predictions and their match flags.
  typedef struct packed {
    logic [CLS_BITS-1:0] pred_k1;
    logic [CLS_BITS-1:0] pred_k3;
    logic [CLS_BITS-1:0] pred_k5;
    logic                hit_k1;
    logic                hit_k3;
    logic                hit_k5;
  } knn_out_t;

  // Labels and control that travel with a finished distance through the queue.
  typedef struct packed {
    logic [CLS_BITS-1:0] train_class;
    logic [CLS_BITS-1:0] query_class;
    logic                end_of_set;
  } knn_tag_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    ST_LIST,
    ST_RANK,
    ST_VOTE
  } knn_state_t;

endpackage

FILE: rtl/knn_l1_classifier.sv
// A result word follows the set-end word through the queue, the list, rank and
// vote states and the result register. Throughput: one pixel word per cycle
// while the queue has room; the back end stops popping during rank and vote at
// each set end, and a 2-entry queue absorbs this. Frequent set ends fill it.
// Reset (rst_n, synchronous, active low) empties the list, accumulator, queue
// and result register; no clearing pass is needed.
// ----------------------------------------------------------------------------
// knn_l1_classifier: k-nearest-neighbor classifier under Manhattan distance
// Front end accumulates distances, a short queue decouples it from the back
// end that keeps the five nearest neighbors and votes for k = 1, 3 and 5.
// ----------------------------------------------------------------------------
module knn_l1_classifier #(
  parameter int DISTANCE_BITS = knn_pkg::DIST_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  knn_pkg::knn_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output knn_pkg::knn_out_t out_data
);
  import knn_pkg::*;

  logic                     push_valid;
  logic                     push_ready;
  logic [DISTANCE_BITS-1:0] push_dist;
  knn_tag_t                 push_tag;
  logic                     pop_valid;
  logic                     pop_ready;
  logic [DISTANCE_BITS-1:0] pop_dist;
  knn_tag_t                 pop_tag;

  // Distance accumulator.
  knn_front #(
    .DISTANCE_BITS (DISTANCE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_dist  (push_dist),
    .push_tag   (push_tag)
  );

  // Queue of finished distances.
  knn_queue #(
    .DISTANCE_BITS (DISTANCE_BITS)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_dist  (push_dist),
    .push_tag   (push_tag),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_dist   (pop_dist),
    .pop_tag    (pop_tag)
  );

  // Neighbor list and vote.
  knn_back #(
    .DISTANCE_BITS (DISTANCE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_dist  (pop_dist),
    .pop_tag   (pop_tag),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/knn_front.sv
// ----------------------------------------------------------------------------
// knn_front: distance accumulator
// Takes one pixel pair per cycle if the queue has room, sums absolute
// differences with saturation and hands each training-vector distance to the queue.
// ----------------------------------------------------------------------------
module knn_front #(
  parameter int DISTANCE_BITS = knn_pkg::DIST_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  knn_pkg::knn_in_t         in_data,
  output logic                     push_valid,
  input  logic                     push_ready,
  output logic [DISTANCE_BITS-1:0] push_dist,
  output knn_pkg::knn_tag_t        push_tag
);
  import knn_pkg::*;

  logic [DISTANCE_BITS-1:0] run_r;
  logic [DISTANCE_BITS-1:0] run_nxt;
  logic [PIXEL_BITS-1:0]    diff;
  logic [DISTANCE_BITS:0]   sum_wide;
  logic [DISTANCE_BITS-1:0] sum_sat;
  logic                     accept;
  logic                     is_end;

  // The front stalls only when the queue has no room.
  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;
  assign is_end   = in_data.end_of_vector || in_data.end_of_set;

  // Absolute difference and saturating sum.
  assign diff = (in_data.query_pixel > in_data.train_pixel) ?
                (in_data.query_pixel - in_data.train_pixel) :
                (in_data.train_pixel - in_data.query_pixel);
  assign sum_wide = {1'b0, run_r} + (DISTANCE_BITS+1)'(diff);
  assign sum_sat  = sum_wide[DISTANCE_BITS] ? {DISTANCE_BITS{1'b1}} :
                    sum_wide[DISTANCE_BITS-1:0];

  // A vector end (or set end) sends the finished distance to the back end.
  assign push_valid           = accept && is_end;
  assign push_dist            = sum_sat;
  assign push_tag.train_class = in_data.train_class;
  assign push_tag.query_class = in_data.query_class;
  assign push_tag.end_of_set  = in_data.end_of_set;

  // Accumulator restarts after every vector end.
  always_comb begin
    run_nxt = run_r;
    if (accept) begin
      run_nxt = is_end ? '0 : sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= '0;
    end else begin
      run_r <= run_nxt;
    end
  end

  // A vector end always leaves the accumulator at zero.
  a_run_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |=> run_r == '0)
    else $error("accumulator not cleared after a vector end");

endmodule

FILE: rtl/knn_queue.sv
// ----------------------------------------------------------------------------
// knn_queue: short queue between front and back end
// Holds finished distances with their labels so that the accumulator keeps
// running while the back end ranks and votes.
// ----------------------------------------------------------------------------
module knn_queue #(
  parameter int DISTANCE_BITS = knn_pkg::DIST_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push_valid,
  output logic                     push_ready,
  input  logic [DISTANCE_BITS-1:0] push_dist,
  input  knn_pkg::knn_tag_t        push_tag,
  output logic                     pop_valid,
  input  logic                     pop_ready,
  output logic [DISTANCE_BITS-1:0] pop_dist,
  output knn_pkg::knn_tag_t        pop_tag
);
  import knn_pkg::*;

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  logic [DISTANCE_BITS-1:0] dist_q [QUEUE_DEPTH];
  knn_tag_t                 tag_q  [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]      wr_ptr_r;
  logic [PTR_BITS-1:0]      rd_ptr_r;
  logic [CNT_BITS-1:0]      count_r;
  logic                     do_push;
  logic                     do_pop;

  assign push_ready = count_r < CNT_BITS'(QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_dist   = dist_q[rd_ptr_r];
  assign pop_tag    = tag_q[rd_ptr_r];

  // Entry storage; no reset needed, the count guards reads.
  always_ff @(posedge clk) begin
    if (do_push) begin
      dist_q[wr_ptr_r] <= push_dist;
      tag_q[wr_ptr_r]  <= push_tag;
    end
  end

  // Pointers wrap naturally since the depth is a power of two.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_BITS'(1);
      end
    end
  end

  // The fill level never passes the depth.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_BITS'(QUEUE_DEPTH))
    else $error("queue fill level out of range");

endmodule

FILE: rtl/knn_back.sv
// ----------------------------------------------------------------------------
// knn_back: neighbor list, ranking and vote
// Inserts each distance into the five-entry list, when full only over a larger one;
// at a set end it ranks the entries, votes for k = 1, 3, 5, loads the result register.
// ----------------------------------------------------------------------------
module knn_back #(
  parameter int DISTANCE_BITS = knn_pkg::DIST_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     pop_valid,
  output logic                     pop_ready,
  input  logic [DISTANCE_BITS-1:0] pop_dist,
  input  knn_pkg::knn_tag_t        pop_tag,
  output logic                     out_valid,
  input  logic                     out_ready,
  output knn_pkg::knn_out_t        out_data
);
  import knn_pkg::*;

  localparam int N = NEIGHBOR_COUNT;

  knn_state_t               state_r;
  knn_state_t               state_nxt;
  logic [N-1:0]             valid_r;
  logic [DISTANCE_BITS-1:0] dist_r [N];
  logic [CLS_BITS-1:0]      cls_r  [N];
  logic [RANK_BITS-1:0]     rank_r [N];
  logic [RANK_BITS-1:0]     rank_c [N];
  logic [CLS_BITS-1:0]      qcls_r;
  logic                     out_valid_r;
  knn_out_t                 out_data_r;

  logic                     rank_load;
  logic                     vote_fire;
  logic                     do_pop;
  logic                     ins_en;
  logic                     full;
  logic                     found;
  logic                     write_ok;
  logic [N-1:0]             empty_sel;
  logic [N-1:0]             is_max;
  logic [N-1:0]             less;
  logic [N-1:0]             ins_sel;

  logic [N-1:0]             voter_c [K_COUNT];
  logic [N-1:0]             win_c   [K_COUNT];
  logic [RANK_BITS-1:0]     cnt_c   [K_COUNT][N];
  logic [CLS_BITS-1:0]      pred_c  [K_COUNT];
  logic [K_COUNT-1:0]       hit_c;

  // Sequencer: next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LIST: begin
        if (pop_valid && pop_tag.end_of_set) begin
          state_nxt = ST_RANK;
        end
      end
      ST_RANK: begin
        state_nxt = ST_VOTE;
      end
      ST_VOTE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_LIST;
        end
      end
      default: begin
        state_nxt = ST_LIST;
      end
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    pop_ready = 1'b0;
    rank_load = 1'b0;
    vote_fire = 1'b0;
    unique case (state_r)
      ST_LIST: pop_ready = 1'b1;
      ST_RANK: rank_load = 1'b1;
      ST_VOTE: vote_fire = !out_valid_r || out_ready;
      default: pop_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LIST;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign do_pop = pop_valid && pop_ready;

  // Insertion slot: lowest empty entry, else the largest distance with the
  // lowest index among equals, taken only if the new distance is smaller.
  always_comb begin
    found     = 1'b0;
    empty_sel = '0;
    for (int i = 0; i < N; i++) begin
      if (!valid_r[i] && !found) begin
        empty_sel[i] = 1'b1;
        found        = 1'b1;
      end
    end
    for (int i = 0; i < N; i++) begin
      is_max[i] = 1'b1;
      less[i]   = pop_dist < dist_r[i];
      for (int j = 0; j < N; j++) begin
        if (j < i) begin
          is_max[i] = is_max[i] && (dist_r[i] > dist_r[j]);
        end else if (j > i) begin
          is_max[i] = is_max[i] && (dist_r[i] >= dist_r[j]);
        end
      end
    end
  end

  assign full     = &valid_r;
  assign ins_sel  = full ? is_max : empty_sel;
  assign write_ok = !full || |(is_max & less);
  assign ins_en   = do_pop && write_ok;

  // Valid bits: set on insertion, all cleared when the vote loads the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (vote_fire) begin
      valid_r <= '0;
    end else if (ins_en) begin
      valid_r <= valid_r | ins_sel;
    end
  end

  // List payload and the query label of the pending set end.
  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      if (ins_en && ins_sel[i]) begin
        dist_r[i] <= pop_dist;
        cls_r[i]  <= pop_tag.train_class;
      end
    end
    if (do_pop && pop_tag.end_of_set) begin
      qcls_r <= pop_tag.query_class;
    end
  end

  // Rank of each valid entry: nearer entries, and equal ones at lower index.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      rank_c[i] = '0;
      for (int j = 0; j < N; j++) begin
        if (j != i && valid_r[j] &&
            ((dist_r[j] < dist_r[i]) || ((dist_r[j] == dist_r[i]) && (j < i)))) begin
          rank_c[i] = rank_c[i] + RANK_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rank_load) begin
      rank_r <= rank_c;
    end
  end

  // Vote for each k: count votes per member class; the winner has the most
  // votes, and among equal counts the lowest rank.
  always_comb begin
    for (int kk = 0; kk < K_COUNT; kk++) begin
      for (int i = 0; i < N; i++) begin
        voter_c[kk][i] = valid_r[i] && (rank_r[i] < K_VALUES[kk]) &&
                         (cls_r[i] < CLS_BITS'(CLASS_COUNT));
      end
      for (int i = 0; i < N; i++) begin
        cnt_c[kk][i] = '0;
        for (int j = 0; j < N; j++) begin
          if (voter_c[kk][j] && (cls_r[j] == cls_r[i])) begin
            cnt_c[kk][i] = cnt_c[kk][i] + RANK_BITS'(1);
          end
        end
      end
      for (int i = 0; i < N; i++) begin
        win_c[kk][i] = voter_c[kk][i];
        for (int j = 0; j < N; j++) begin
          if (j != i && voter_c[kk][j] &&
              !((cnt_c[kk][i] > cnt_c[kk][j]) ||
                ((cnt_c[kk][i] == cnt_c[kk][j]) && (rank_r[i] < rank_r[j])))) begin
            win_c[kk][i] = 1'b0;
          end
        end
      end
      pred_c[kk] = '0;
      for (int i = 0; i < N; i++) begin
        if (win_c[kk][i]) begin
          pred_c[kk] = pred_c[kk] | cls_r[i];
        end
      end
      hit_c[kk] = (|voter_c[kk]) && (pred_c[kk] == qcls_r);
    end
  end

  // Result register: the list is free again while the word waits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (vote_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (vote_fire) begin
      out_data_r.pred_k1 <= pred_c[0];
      out_data_r.pred_k3 <= pred_c[1];
      out_data_r.pred_k5 <= pred_c[2];
      out_data_r.hit_k1  <= hit_c[0];
      out_data_r.hit_k3  <= hit_c[1];
      out_data_r.hit_k5  <= hit_c[2];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The list fills from the lowest entry up, so valid bits form a low run.
  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((valid_r + N'(1)) & valid_r) == '0)
    else $error("neighbor list has a hole");

  // A set end taken from the queue starts the ranking step next.
  a_set_end_ranks: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && pop_tag.end_of_set) |=> state_r == ST_RANK)
    else $error("set end did not start ranking");

  // Issuing a result shows a word and empties the list.
  a_vote_clears: assert property (@(posedge clk) disable iff (!rst_n)
    vote_fire |=> (out_valid_r && valid_r == '0))
    else $error("result issue did not clear the list");

endmodule
